// File: rtl/core/asn1t_pkg.sv
// Shared types, codes and tables of the ASN.1 time decoder.
package asn1t_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] TAG_UTC_TIME = 16'd23;
    localparam logic [15:0] TAG_GEN_TIME = 16'd24;
    localparam logic [4:0]  LEN_UTC      = 5'd13;
    localparam logic [4:0]  LEN_GEN      = 5'd15;
    localparam logic [4:0]  DIGITS_UTC   = 5'd12;
    localparam logic [4:0]  DIGITS_GEN   = 5'd14;
    localparam logic [4:0]  COUNT_MAX    = 5'd16;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [7:0]  CHAR_ZULU    = 8'h5A;
    localparam logic [6:0]  UTC_PIVOT    = 7'd50;
    localparam logic [13:0] BASE_1900    = 14'd1900;
    localparam logic [13:0] BASE_2000    = 14'd2000;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_UTC  = 2'd1,
        KIND_GEN  = 2'd2,
        KIND_BAD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ENCODING = 2'd1,
        ST_RANGE    = 2'd2,
        ST_TAG      = 2'd3
    } status_t;

    // One finished element handed from the front to the back.
    typedef struct packed {
        kind_t      kind;
        logic       enc_err;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } elem_t;

    typedef struct packed {
        status_t     status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        is_generalized;
    } result_t;

    // Days in a month for a common year; month is 1..12.
    function automatic logic [4:0] days_in_month(input logic [3:0] month);
        logic [4:0] dim;
        case (month)
            4'd2:                      dim = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
            default:                   dim = 5'd31;
        endcase
        return dim;
    endfunction

endpackage

// File: rtl/core/asn1_time_decoder.sv
// Top level of the ASN.1 UTCTime / GeneralizedTime decoder.
//
// Accepts the content bytes of one DER time element, one byte per item, at a sustained
// rate of one item per clock cycle while full is low; the tag fields are taken from the
// first item of each element and the item flagged last_byte closes it. Each element yields
// exactly one result on the output queue. The finished element enters the queue at the edge
// that accepts its last item and moves into the output register at the next edge if that
// register is free. Finished elements wait in a queue of QUEUE_DEPTH entries ahead of a
// one-entry output register; full rises only when that queue is full because results are
// not being popped, and it then holds off every input item. Any error status comes with
// all time fields at zero.
module asn1_time_decoder
    import asn1t_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  tag_class,
    input  logic        is_constructed,
    input  logic [15:0] tag_number,
    input  logic [7:0]  content_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic        is_generalized
);

    localparam int ELEM_W = $bits(elem_t);

    logic    q_full, q_empty, q_wr, q_rd;
    elem_t   front_elem, back_elem;
    result_t result;

    asn1t_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .tag_class      (tag_class),
        .is_constructed (is_constructed),
        .tag_number     (tag_number),
        .content_byte   (content_byte),
        .byte_present   (byte_present),
        .last_byte      (last_byte),
        .queue_full     (q_full),
        .elem_valid     (q_wr),
        .elem           (front_elem)
    );

    asn1t_fifo #(
        .WIDTH (ELEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (front_elem),
        .rd_en   (q_rd),
        .rd_data (back_elem),
        .full    (q_full),
        .empty   (q_empty)
    );

    asn1t_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_avail (!q_empty),
        .elem       (back_elem),
        .elem_take  (q_rd),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    assign status         = result.status;
    assign year           = result.year;
    assign month          = result.month;
    assign day            = result.day;
    assign hour           = result.hour;
    assign minute         = result.minute;
    assign second         = result.second;
    assign is_generalized = result.is_generalized;

endmodule

// File: rtl/core/asn1t_fifo.sv
// Small register queue that carries finished elements from front to back.
module asn1t_fifo
    import asn1t_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("front wrote into a full queue");
`endif

endmodule

// File: rtl/core/asn1t_front.sv
// Front part: takes content bytes, reads the tag and accumulates digit pairs.
module asn1t_front
    import asn1t_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  tag_class,
    input  logic        is_constructed,
    input  logic [15:0] tag_number,
    input  logic [7:0]  content_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    input  logic        queue_full,
    output logic        elem_valid,
    output elem_t       elem
);

    typedef enum logic [2:0] {
        F_YH = 3'd0,
        F_YL = 3'd1,
        F_MO = 3'd2,
        F_DY = 3'd3,
        F_HR = 3'd4,
        F_MI = 3'd5,
        F_SE = 3'd6
    } field_t;

    logic [4:0] count_reg, count_next;
    kind_t      kind_reg, kind_eff;
    logic [6:0] yh_reg, yl_reg, mo_reg, dy_reg, hr_reg, mi_reg, se_reg;
    logic [6:0] yh_next, yl_next, mo_next, dy_next, hr_next, mi_next, se_next;
    logic       derr_reg, derr_next;
    logic       zulu_reg, zulu_next;
    kind_t      tag_kind;
    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [4:0] ndig;
    logic [4:0] want;
    field_t     field;
    logic [6:0] acc_sel, acc_new;

    assign full       = queue_full;
    assign accept     = push && !queue_full;
    assign elem_valid = accept && last_byte;

    always_comb
    begin
        if (tag_class == 2'd0 && !is_constructed && tag_number == TAG_UTC_TIME)
        begin
            tag_kind = KIND_UTC;
        end
        else if (tag_class == 2'd0 && !is_constructed && tag_number == TAG_GEN_TIME)
        begin
            tag_kind = KIND_GEN;
        end
        else
        begin
            tag_kind = KIND_BAD;
        end
    end

    assign kind_eff = (kind_reg == KIND_NONE) ? tag_kind : kind_reg;
    assign is_digit = (content_byte >= CHAR_ZERO) && (content_byte <= CHAR_NINE);
    assign digit    = 4'(content_byte - CHAR_ZERO);

    always_comb
    begin
        case (kind_eff)
            KIND_UTC: ndig = DIGITS_UTC;
            KIND_GEN: ndig = DIGITS_GEN;
            default:  ndig = 5'd0;
        endcase
    end

    // A GeneralizedTime year is kept as its century and its last two digits.
    always_comb
    begin
        if (kind_eff == KIND_GEN)
        begin
            if (count_reg < 5'd2)
            begin
                field = F_YH;
            end
            else if (count_reg < 5'd4)
            begin
                field = F_YL;
            end
            else
            begin
                field = field_t'(3'(((count_reg - 5'd4) >> 1) + 5'd2));
            end
        end
        else
        begin
            field = field_t'(3'((count_reg >> 1) + 5'd1));
        end
    end

    always_comb
    begin
        case (field)
            F_YH:    acc_sel = yh_reg;
            F_YL:    acc_sel = yl_reg;
            F_MO:    acc_sel = mo_reg;
            F_DY:    acc_sel = dy_reg;
            F_HR:    acc_sel = hr_reg;
            F_MI:    acc_sel = mi_reg;
            default: acc_sel = se_reg;
        endcase
    end

    assign acc_new = 7'((11'(acc_sel) * 11'd10) + 11'(digit));

    always_comb
    begin
        yh_next   = yh_reg;
        yl_next   = yl_reg;
        mo_next   = mo_reg;
        dy_next   = dy_reg;
        hr_next   = hr_reg;
        mi_next   = mi_reg;
        se_next   = se_reg;
        derr_next = derr_reg;
        zulu_next = zulu_reg;
        count_next = count_reg;
        if (byte_present)
        begin
            zulu_next = (content_byte == CHAR_ZULU);
            if (count_reg < COUNT_MAX)
            begin
                count_next = count_reg + 5'd1;
            end
            if (count_reg < ndig)
            begin
                if (!is_digit)
                begin
                    derr_next = 1'b1;
                end
                else
                begin
                    case (field)
                        F_YH:    yh_next = acc_new;
                        F_YL:    yl_next = acc_new;
                        F_MO:    mo_next = acc_new;
                        F_DY:    dy_next = acc_new;
                        F_HR:    hr_next = acc_new;
                        F_MI:    mi_next = acc_new;
                        default: se_next = acc_new;
                    endcase
                end
            end
        end
    end

    assign want = (kind_eff == KIND_GEN) ? LEN_GEN : LEN_UTC;

    always_comb
    begin
        elem.kind    = kind_eff;
        elem.enc_err = (count_next != want) || !zulu_next || derr_next;
        elem.year_hi = yh_next;
        elem.year_lo = yl_next;
        elem.month   = mo_next;
        elem.day     = dy_next;
        elem.hour    = hr_next;
        elem.minute  = mi_next;
        elem.second  = se_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            kind_reg  <= KIND_NONE;
            yh_reg    <= '0;
            yl_reg    <= '0;
            mo_reg    <= '0;
            dy_reg    <= '0;
            hr_reg    <= '0;
            mi_reg    <= '0;
            se_reg    <= '0;
            derr_reg  <= 1'b0;
            zulu_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                kind_reg  <= KIND_NONE;
                yh_reg    <= '0;
                yl_reg    <= '0;
                mo_reg    <= '0;
                dy_reg    <= '0;
                hr_reg    <= '0;
                mi_reg    <= '0;
                se_reg    <= '0;
                derr_reg  <= 1'b0;
                zulu_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                kind_reg  <= kind_eff;
                yh_reg    <= yh_next;
                yl_reg    <= yl_next;
                mo_reg    <= mo_next;
                dy_reg    <= dy_next;
                hr_reg    <= hr_next;
                mi_reg    <= mi_next;
                se_reg    <= se_next;
                derr_reg  <= derr_next;
                zulu_reg  <= zulu_next;
            end
        end
    end

endmodule

// File: rtl/core/asn1t_back.sv
// Back part: range checks one element and holds its result for the consumer.
module asn1t_back
    import asn1t_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    elem_avail,
    input  elem_t   elem,
    output logic    elem_take,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic        out_valid_reg;
    result_t     result_reg, result_next;
    logic        is_gen;
    logic [13:0] year_gen, year_utc, year_val;
    logic        leap;
    logic [4:0]  dim;
    logic        month_ok, day_ok, range_ok;

    assign empty     = !out_valid_reg;
    assign result    = result_reg;
    assign elem_take = elem_avail && (!out_valid_reg || pop);

    assign is_gen   = (elem.kind == KIND_GEN);
    assign year_gen = 14'((14'(elem.year_hi) * 14'd100) + 14'(elem.year_lo));
    assign year_utc = (elem.year_lo >= UTC_PIVOT) ? BASE_1900 + 14'(elem.year_lo)
                                                  : BASE_2000 + 14'(elem.year_lo);
    assign year_val = is_gen ? year_gen : year_utc;

    // Leap years follow from the last two digits and, on a century, from the century.
    // A UTCTime century year is always 2000, which is a leap year.
    assign leap = (elem.year_lo[1:0] == 2'd0) &&
                  ((elem.year_lo != 7'd0) || !is_gen || (elem.year_hi[1:0] == 2'd0));

    assign month_ok = (elem.month >= 7'd1) && (elem.month <= 7'd12);
    assign dim      = (elem.month == 7'd2 && leap) ? 5'd29 : days_in_month(elem.month[3:0]);
    assign day_ok   = (elem.day >= 7'd1) && (elem.day <= 7'(dim));
    assign range_ok = month_ok && day_ok && (elem.hour <= 7'd23) &&
                      (elem.minute <= 7'd59) && (elem.second <= 7'd59);

    always_comb
    begin
        result_next = '0;
        if (elem.kind == KIND_BAD)
        begin
            result_next.status = ST_TAG;
        end
        else if (elem.enc_err)
        begin
            result_next.status = ST_ENCODING;
        end
        else if (!range_ok)
        begin
            result_next.status = ST_RANGE;
        end
        else
        begin
            result_next.status         = ST_OK;
            result_next.year           = year_val;
            result_next.month          = elem.month[3:0];
            result_next.day            = elem.day[4:0];
            result_next.hour           = elem.hour[4:0];
            result_next.minute         = elem.minute[5:0];
            result_next.second         = elem.second[5:0];
            result_next.is_generalized = is_gen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (elem_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_take)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_error_zeroes_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status != ST_OK) |->
            (result_reg.year == '0 && result_reg.month == '0 && result_reg.day == '0 &&
             result_reg.hour == '0 && result_reg.minute == '0 &&
             result_reg.second == '0 && !result_reg.is_generalized))
        else $error("error result carries nonzero fields");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(result_reg)))
        else $error("waiting result changed or was dropped");
`endif

endmodule
